// ===== rtl/dtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types, codes and helpers of the deadline timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned DEF_SLOTS = 16;
  localparam int unsigned ID_W = 4;
  localparam logic [TIME_W-1:0] DEF_ROLLBACK_LIMIT = 48'd3600000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    REQ_ADD     = 3'd0,
    REQ_CANCEL  = 3'd1,
    REQ_REFRESH = 3'd2,
    REQ_RESET   = 3'd3,
    REQ_TICK    = 3'd4,
    REQ_QUERY   = 3'd5
  } dtt_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_APPLY,
    ST_SCAN,
    ST_FINISH
  } dtt_state_e;

  typedef enum logic [2:0] {
    COP_NONE,
    COP_LOAD,
    COP_FREE,
    COP_REFRESH,
    COP_SETPER,
    COP_DUE,
    COP_EXPIRE
  } dtt_cop_e;

  typedef struct packed {
    dtt_cop_e          op;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] period;
    logic              rep;
    logic              roll;
  } dtt_cmd_t;

  typedef struct packed {
    logic              valid;
    logic              rep;
    logic              due;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] deadline;
  } dtt_cell_st_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

// ===== rtl/deadline_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_table
// Timer slot table with ordered expiry, built as a row of slot cells.
// ----------------------------------------------------------------------------
// steps: cancel, refresh and unknown requests answer from prep, as do an add to a
//   full table and a reset that fails or keeps its period without rel_now; other adds
//   and resets go through apply and one scan over the cell row, query through one scan
// tick: an empty table answers from prep, else one scan per result
// throughput: one transaction in flight; a result waits in the output register
// reset clears valid marks, front notice and previous time; rollback limit 3600000 ms
module deadline_timer_table
  import dtt_pkg::*;
#(
  parameter int unsigned SLOTS = DEF_SLOTS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [47:0]   cfg_wdata_i,        // rollback_limit_ms
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // now_ms[47:0], timer_id[51:48], period_ms[99:52], repeat_flag[100],
  // rel_now[101]
  input  logic [103:0]  s_axis_tdata_i,
  // req_type[2:0]
  input  logic [2:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // ok[0], slot_id[4:1], front_hit[5], remaining_ms[53:6]
  output logic [55:0]   m_axis_tdata_o,
  output logic          m_axis_tlast_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_K = IW'(SLOTS - 1);

  dtt_state_e        state_q, state_d;
  logic [2:0]        req_q, req_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [TIME_W-1:0] per_q, per_d;
  logic              rep_q, rep_d;
  logic              fnow_q, fnow_d;
  logic              idok_q, idok_d;
  logic [IW-1:0]     tgt_q, tgt_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [IW-1:0]     k_q, k_d;
  logic              found_q, found_d;
  logic [TIME_W-1:0] bdl_q, bdl_d;
  logic [IW-1:0]     bidx_q, bidx_d;
  logic              notice_q, notice_d;
  logic [TIME_W-1:0] prev_q, prev_d;
  logic [TIME_W-1:0] limit_q;
  logic              ovalid_q, ovalid_d;
  logic              ook_q, ook_d;
  logic [ID_W-1:0]   oid_q, oid_d;
  logic              oaf_q, oaf_d;
  logic [TIME_W-1:0] orem_q, orem_d;
  logic              olast_q, olast_d;

  dtt_cmd_t          cmd;
  logic [IW-1:0]     csel;
  dtt_cell_st_t      st [SLOTS];

  logic              ofree;
  logic              any_valid;
  logic              have_free;
  logic [IW-1:0]     free_idx;
  logic [SLOTS-1:0]  due_rest;
  logic              cand;
  dtt_cell_st_t      kst;
  dtt_cell_st_t      tst;
  dtt_cell_st_t      ist;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dtt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sel_i  (csel == IW'(g)),
      .cmd_i  (cmd),
      .st_o   (st[g])
    );
  end

  assign ofree = !ovalid_q || m_axis_tready_i;
  assign kst   = st[k_q];
  assign tst   = st[tgt_q];
  assign ist   = st[tgt_q];

  always_comb begin
    any_valid = 1'b0;
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (st[i].valid) any_valid = 1'b1;
      if (!st[i].valid) begin
        have_free = 1'b1;
        free_idx  = IW'(i);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      due_rest[i] = st[i].due && (IW'(i) != bidx_q);
    end
  end

  always_comb begin
    case (req_q)
      REQ_TICK: cand = kst.due;
      REQ_QUERY: cand = kst.valid;
      default: cand = kst.valid && (k_q != tgt_q);
    endcase
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    now_d    = now_q;
    per_d    = per_q;
    rep_d    = rep_q;
    fnow_d   = fnow_q;
    idok_d   = idok_q;
    tgt_d    = tgt_q;
    start_d  = start_q;
    k_d      = k_q;
    found_d  = found_q;
    bdl_d    = bdl_q;
    bidx_d   = bidx_q;
    notice_d = notice_q;
    prev_d   = prev_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    ook_d    = ook_q;
    oid_d    = oid_q;
    oaf_d    = oaf_q;
    orem_d   = orem_q;
    olast_d  = olast_q;
    cmd      = '{op: COP_NONE, now: now_q, base: now_q, period: per_q, rep: rep_q,
                 roll: 1'b0};
    csel     = tgt_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d   = s_axis_tuser_i;
          now_d   = s_axis_tdata_i[47:0];
          tgt_d   = IW'(s_axis_tdata_i[51:48]);
          idok_d  = 32'(s_axis_tdata_i[51:48]) < SLOTS;
          per_d   = s_axis_tdata_i[99:52];
          rep_d   = s_axis_tdata_i[100];
          fnow_d  = s_axis_tdata_i[101];
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (ofree) begin
          ook_d   = 1'b0;
          oid_d   = '0;
          oaf_d   = 1'b0;
          orem_d  = '0;
          olast_d = 1'b1;
          k_d     = '0;
          found_d = 1'b0;
          case (req_q)
            REQ_ADD: begin
              if (have_free) begin
                tgt_d   = free_idx;
                state_d = ST_APPLY;
              end else begin
                ovalid_d = 1'b1;
                state_d  = ST_IDLE;
              end
            end
            REQ_CANCEL: begin
              ook_d    = idok_q && ist.valid;
              cmd.op   = (idok_q && ist.valid) ? COP_FREE : COP_NONE;
              ovalid_d = 1'b1;
              state_d  = ST_IDLE;
            end
            REQ_REFRESH: begin
              ook_d    = idok_q && ist.valid;
              cmd.op   = (idok_q && ist.valid) ? COP_REFRESH : COP_NONE;
              ovalid_d = 1'b1;
              state_d  = ST_IDLE;
            end
            REQ_RESET: begin
              if (!idok_q || !ist.valid) begin
                ovalid_d = 1'b1;
                state_d  = ST_IDLE;
              end else if ((per_q == ist.period) && !fnow_q) begin
                ook_d    = 1'b1;
                ovalid_d = 1'b1;
                state_d  = ST_IDLE;
              end else begin
                if (fnow_q) begin
                  start_d = now_q;
                end else if (ist.deadline >= ist.period) begin
                  start_d = ist.deadline - ist.period;
                end else begin
                  start_d = '0;
                end
                state_d = ST_APPLY;
              end
            end
            REQ_TICK: begin
              if (!any_valid) begin
                ovalid_d = 1'b1;
                state_d  = ST_IDLE;
              end else begin
                cmd.op   = COP_DUE;
                cmd.roll = (now_q < prev_q) && ((prev_q - now_q) > limit_q);
                prev_d   = now_q;
                state_d  = ST_SCAN;
              end
            end
            REQ_QUERY: begin
              notice_d = 1'b0;
              state_d  = ST_SCAN;
            end
            default: begin
              ovalid_d = 1'b1;
              state_d  = ST_IDLE;
            end
          endcase
        end
      end
      ST_APPLY: begin
        if (req_q == REQ_ADD) begin
          cmd.op = COP_LOAD;
        end else begin
          cmd.op   = COP_SETPER;
          cmd.base = start_q;
        end
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cand && (!found_q || (kst.deadline < bdl_q))) begin
          found_d = 1'b1;
          bdl_d   = kst.deadline;
          bidx_d  = k_q;
        end
        k_d = k_q + 1'b1;
        if (k_q == LAST_K) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (ofree) begin
          ovalid_d = 1'b1;
          ook_d    = 1'b1;
          oid_d    = '0;
          oaf_d    = 1'b0;
          orem_d   = '0;
          olast_d  = 1'b1;
          k_d      = '0;
          found_d  = 1'b0;
          state_d  = ST_IDLE;
          case (req_q)
            REQ_TICK: begin
              if (!found_q) begin
                ook_d = 1'b0;
              end else begin
                oid_d   = ID_W'(bidx_q);
                olast_d = (due_rest == '0);
                cmd.op  = COP_EXPIRE;
                csel    = bidx_q;
                if (due_rest != '0) state_d = ST_SCAN;
              end
            end
            REQ_QUERY: begin
              if (!found_q) begin
                orem_d = TIME_MAX;
              end else if (now_q >= bdl_q) begin
                orem_d = '0;
              end else begin
                orem_d = bdl_q - now_q;
              end
            end
            default: begin
              if (req_q == REQ_ADD) oid_d = ID_W'(tgt_q);
              if (!(found_q && ((bdl_q < tst.deadline) ||
                  ((bdl_q == tst.deadline) && (bidx_q < tgt_q)))) && !notice_q) begin
                oaf_d    = 1'b1;
                notice_d = 1'b1;
              end
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      notice_q <= 1'b0;
      prev_q   <= '0;
      limit_q  <= DEF_ROLLBACK_LIMIT;
      ovalid_q <= 1'b0;
      k_q      <= '0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      notice_q <= notice_d;
      prev_q   <= prev_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    now_q   <= now_d;
    per_q   <= per_d;
    rep_q   <= rep_d;
    fnow_q  <= fnow_d;
    idok_q  <= idok_d;
    tgt_q   <= tgt_d;
    start_q <= start_d;
    bdl_q   <= bdl_d;
    bidx_q  <= bidx_d;
    ook_q   <= ook_d;
    oid_q   <= oid_d;
    oaf_q   <= oaf_d;
    orem_q  <= orem_d;
    olast_q <= olast_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {2'b00, orem_q, oaf_q, oid_q, ook_q};
  assign m_axis_tlast_o  = olast_q;

`ifndef SYNTHESIS
  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == ST_PREP))
    else $error("accepted transaction did not enter prep");
  a_tick_best_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && (req_q == REQ_TICK) && found_q) |-> st[bidx_q].due)
    else $error("tick selected an entry that is not due");
  a_notice_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(notice_q) |-> $past(state_q == ST_FINISH))
    else $error("front notice raised outside finish");
`endif

endmodule

// ===== rtl/dtt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_cell
// One timer slot: valid, recurring flag, period, deadline and due mark.
// ----------------------------------------------------------------------------
module dtt_cell
  import dtt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         sel_i,
  input  dtt_cmd_t     cmd_i,
  output dtt_cell_st_t st_o
);

  logic              valid_q, valid_d;
  logic              rep_q, rep_d;
  logic              due_q, due_d;
  logic [TIME_W-1:0] per_q, per_d;
  logic [TIME_W-1:0] dl_q, dl_d;

  always_comb begin
    valid_d = valid_q;
    rep_d   = rep_q;
    due_d   = due_q;
    per_d   = per_q;
    dl_d    = dl_q;
    case (cmd_i.op)
      COP_LOAD: begin
        if (sel_i) begin
          valid_d = 1'b1;
          rep_d   = cmd_i.rep;
          per_d   = cmd_i.period;
          dl_d    = sat_add(cmd_i.base, cmd_i.period);
        end
      end
      COP_SETPER: begin
        if (sel_i) begin
          per_d = cmd_i.period;
          dl_d  = sat_add(cmd_i.base, cmd_i.period);
        end
      end
      COP_FREE: begin
        if (sel_i) valid_d = 1'b0;
      end
      COP_REFRESH: begin
        if (sel_i) dl_d = sat_add(cmd_i.now, per_q);
      end
      COP_DUE: begin
        due_d = valid_q && (cmd_i.roll || (dl_q <= cmd_i.now));
      end
      COP_EXPIRE: begin
        if (sel_i) begin
          due_d = 1'b0;
          if (rep_q) begin
            dl_d = sat_add(cmd_i.now, per_q);
          end else begin
            valid_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rep_q   <= 1'b0;
      due_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rep_q   <= rep_d;
      due_q   <= due_d;
    end
  end

  always_ff @(posedge clk_i) begin
    per_q <= per_d;
    dl_q  <= dl_d;
  end

  assign st_o = '{valid: valid_q, rep: rep_q, due: due_q, period: per_q, deadline: dl_q};

endmodule

// ===== tb/deadline_timer_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_table_tb
// Self-checking bench for the deadline timer table. Requests are streamed in
// with random gaps (none in one phase), results are compared field by field
// against an internal predictor of the slot table, and the rollback limit is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module deadline_timer_table_tb;
  import dtt_pkg::*;

  localparam int unsigned NSLOT = 16;
  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic              rel_now;
    logic              rep;
    logic [TIME_W-1:0] period;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
    logic [2:0]        req;
  } timer_req_t;

  typedef struct packed {
    logic              last;
    logic [TIME_W-1:0] rem;
    logic              front_hit;
    logic [ID_W-1:0]   id;
    logic              ok;
  } timer_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [47:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic [2:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  deadline_timer_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tlast_o(m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [TIME_W-1:0] p_limit;
  logic              p_valid [NSLOT];
  logic              p_rep [NSLOT];
  logic [TIME_W-1:0] p_period [NSLOT];
  logic [TIME_W-1:0] p_deadline [NSLOT];
  logic [TIME_W-1:0] p_prev;
  logic              p_notice;

  timer_req_t req_q[$];
  timer_rsp_t expected_rsp_q[$];
  int unsigned mismatches = 0;
  int unsigned wdog = 0;
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;
  logic in_taken = 1'b0;

  function automatic logic [TIME_W-1:0] sum_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic bit earlier(int a, int b);
    if (p_deadline[a] != p_deadline[b]) return p_deadline[a] < p_deadline[b];
    return a < b;
  endfunction

  function automatic bit front_notice(int s);
    bit f;
    f = !p_notice;
    for (int j = 0; j < NSLOT; j++)
      if (j != s && p_valid[j] && earlier(j, s)) f = 0;
    if (f) p_notice = 1'b1;
    return f;
  endfunction

  function automatic void push_rsp(bit ok, int id, bit af, logic [TIME_W-1:0] rem, bit last);
    timer_rsp_t r;
    r.ok = ok; r.id = id[ID_W-1:0]; r.front_hit = af; r.rem = rem; r.last = last;
    expected_rsp_q.insert(expected_rsp_q.size(), r);
  endfunction

  function automatic void predict_timer(timer_req_t t);
    int s, best, n;
    int lst[$];
    bit any, roll, af;
    logic [TIME_W-1:0] start;
    case (t.req)
      REQ_ADD: begin
        s = -1;
        for (int k = NSLOT - 1; k >= 0; k--) if (!p_valid[k]) s = k;
        if (s < 0) push_rsp(0, 0, 0, 0, 1);
        else begin
          p_valid[s] = 1; p_rep[s] = t.rep; p_period[s] = t.period;
          p_deadline[s] = sum_sat(t.now, t.period);
          af = front_notice(s);
          push_rsp(1, s, af, 0, 1);
        end
      end
      REQ_CANCEL: begin
        any = p_valid[t.id];
        p_valid[t.id] = 0;
        push_rsp(any, 0, 0, 0, 1);
      end
      REQ_REFRESH: begin
        any = p_valid[t.id];
        if (any) p_deadline[t.id] = sum_sat(t.now, p_period[t.id]);
        push_rsp(any, 0, 0, 0, 1);
      end
      REQ_RESET: begin
        if (!p_valid[t.id]) push_rsp(0, 0, 0, 0, 1);
        else if (t.period == p_period[t.id] && !t.rel_now) push_rsp(1, 0, 0, 0, 1);
        else begin
          if (t.rel_now) start = t.now;
          else if (p_deadline[t.id] >= p_period[t.id])
            start = p_deadline[t.id] - p_period[t.id];
          else start = 0;
          p_period[t.id] = t.period;
          p_deadline[t.id] = sum_sat(start, t.period);
          af = front_notice(t.id);
          push_rsp(1, 0, af, 0, 1);
        end
      end
      REQ_TICK: begin
        any = 0;
        for (int k = 0; k < NSLOT; k++) if (p_valid[k]) any = 1;
        if (!any) push_rsp(0, 0, 0, 0, 1);
        else begin
          roll = t.now < p_prev && (p_prev - t.now) > p_limit;
          p_prev = t.now;
          for (int k = 0; k < NSLOT; k++)
            if (p_valid[k] && (roll || p_deadline[k] <= t.now)) lst.insert(lst.size(), k);
          n = lst.size();
          if (n == 0) push_rsp(0, 0, 0, 0, 1);
          else begin
            for (int i = 1; i < n; i++) begin
              for (int j = i; j > 0 && earlier(lst[j], lst[j-1]); j--) begin
                best = lst[j]; lst[j] = lst[j-1]; lst[j-1] = best;
              end
            end
            for (int i = 0; i < n; i++) begin
              s = lst[i];
              push_rsp(1, s, 0, 0, i == n - 1);
              if (p_rep[s]) p_deadline[s] = sum_sat(t.now, p_period[s]);
              else p_valid[s] = 0;
            end
          end
        end
      end
      REQ_QUERY: begin
        p_notice = 0;
        any = 0; best = 0;
        for (int k = 0; k < NSLOT; k++)
          if (p_valid[k] && (!any || earlier(k, best))) begin
            best = k; any = 1;
          end
        if (!any) push_rsp(1, 0, 0, '1, 1);
        else if (t.now >= p_deadline[best]) push_rsp(1, 0, 0, 0, 1);
        else push_rsp(1, 0, 0, p_deadline[best] - t.now, 1);
      end
      default: push_rsp(0, 0, 0, 0, 1);
    endcase
  endfunction

  // driver
  always @(negedge clk_i) begin
    timer_req_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (req_q.size() > 0 && !hold_off && (no_idle || $urandom_range(99) >= 26)) begin
          nxt = req_q.pop_front();
          s_axis_tuser_i <= nxt.req;
          s_axis_tdata_i <= {2'd0, nxt[104:3]};
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= no_idle || ($urandom_range(99) >= 26);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    timer_rsp_t got, exp_r;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o)
        predict_timer(timer_req_t'({s_axis_tdata_i[101:0], s_axis_tuser_i}));
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        wdog <= 0;
      else
        wdog <= wdog + 1;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tlast_o, m_axis_tdata_o[53:0]};
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_rsp_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %b/%0d/%b/%h/%b got %b/%0d/%b/%h/%b",
                       exp_r.ok, exp_r.id, exp_r.front_hit, exp_r.rem, exp_r.last,
                       got.ok, got.id, got.front_hit, got.rem, got.last);
          end
        end
      end
      if (wdog >= WDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [TIME_W-1:0] rnd48();
    return {16'($urandom_range(16'hffff)), $urandom()};
  endfunction

  task automatic add_req(logic [2:0] rq, logic [TIME_W-1:0] now, logic [3:0] id,
                         logic [TIME_W-1:0] per, bit rep, bit fnow);
    timer_req_t t;
    t.req = rq; t.now = now; t.id = id; t.period = per; t.rep = rep; t.rel_now = fnow;
    req_q.insert(req_q.size(), t);
  endtask

  task automatic wait_drained();
    while (req_q.size() > 0 || s_axis_tvalid_i || expected_rsp_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [TIME_W-1:0] v);
    @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    p_limit = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly small times so deadlines land near now; some wide values
  task automatic random_phase(int cnt, logic [TIME_W-1:0] base);
    logic [TIME_W-1:0] clock_ms, per;
    int r;
    clock_ms = base;
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(99);
      per = ($urandom_range(9) == 0) ? rnd48() : 48'($urandom_range(200));
      if ($urandom_range(19) != 0) clock_ms = sum_sat(clock_ms, 48'($urandom_range(60)));
      else if ($urandom_range(1)) clock_ms = rnd48();
      else clock_ms = (clock_ms > 5000) ? clock_ms - 48'($urandom_range(5000)) : '0;
      if (r < 25) add_req(REQ_ADD, clock_ms, 4'd0, per, 1'($urandom_range(1)),
                          1'($urandom_range(1)));
      else if (r < 33) add_req(REQ_CANCEL, clock_ms, 4'($urandom_range(15)), per, 0, 0);
      else if (r < 41) add_req(REQ_REFRESH, clock_ms, 4'($urandom_range(15)), per, 0, 0);
      else if (r < 51) add_req(REQ_RESET, clock_ms, 4'($urandom_range(15)), per,
                               1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (r < 80) add_req(REQ_TICK, clock_ms, 4'($urandom_range(15)), per,
                               1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (r < 95) add_req(REQ_QUERY, clock_ms, 4'($urandom_range(15)), per, 0, 0);
      else add_req(3'(6 + $urandom_range(1)), rnd48(), 4'($urandom_range(15)), rnd48(),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    p_limit = DEF_ROLLBACK_LIMIT;
    for (int k = 0; k < NSLOT; k++) begin
      p_valid[k] = 0; p_rep[k] = 0; p_period[k] = 0; p_deadline[k] = 0;
    end
    p_prev = 0; p_notice = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: empty table, full table, saturation, resets, a backwards tick
    add_req(REQ_TICK, 100, 0, 0, 0, 0);
    add_req(REQ_QUERY, 0, 0, 0, 0, 0);
    add_req(REQ_CANCEL, 0, 15, 0, 0, 0);
    add_req(REQ_REFRESH, 0, 3, 0, 0, 0);
    add_req(REQ_RESET, 0, 2, 0, 0, 1);
    for (int k = 0; k < NSLOT; k++)
      add_req(REQ_ADD, 1000, 0, (k == 0) ? '1 : 48'(k * 7 % 5), k[0], 0);
    add_req(REQ_ADD, '1, 0, '1, 1, 1);
    add_req(REQ_QUERY, 1000, 0, 0, 0, 0);
    add_req(REQ_RESET, 2000, 0, 10, 0, 1);
    add_req(REQ_RESET, 2000, 1, 0, 0, 0);
    add_req(REQ_RESET, 2000, 1, 0, 0, 0);
    add_req(REQ_REFRESH, '1, 2, 0, 0, 0);
    add_req(REQ_TICK, 1003, 0, 0, 0, 0);
    add_req(REQ_TICK, 0, 0, 0, 0, 0);
    add_req(3'd6, '1, 15, '1, 1, 1);
    add_req(3'd7, 0, 0, 0, 0, 0);
    wait_drained();

    // rollback limit extremes and a random middle value
    set_limit(0);
    random_phase(60, 0);
    wait_drained();
    set_limit('1);
    random_phase(60, 48'h7fff_0000_0000);
    repeat (150) @(posedge clk_i);
    // sender pauses until all outstanding results are back
    hold_off = 1'b1;
    do @(negedge clk_i); while (s_axis_tvalid_i || expected_rsp_q.size() > 0);
    hold_off = 1'b0;
    no_idle = 1'b1;
    random_phase(40, 1000);
    wait_drained();
    no_idle = 1'b0;
    set_limit(rnd48() >> $urandom_range(47));
    random_phase(80, 5000);
    wait_drained();

    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
